// File: hdl/cte_pkg.sv
package cte_pkg;

   // Table geometry
   localparam int PROCESSES = 16;
   localparam int ENTRIES   = 16;
   localparam int SLOTS     = PROCESSES * ENTRIES;

   localparam int PROC_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSFER_MASK = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_TYPE     = 8'd1;

   // Operation codes
   localparam logic [2:0] MODE_CREATE   = 3'd0;
   localparam logic [2:0] MODE_CHECK    = 3'd1;
   localparam logic [2:0] MODE_REVOKE   = 3'd2;
   localparam logic [2:0] MODE_FIND     = 3'd3;
   localparam logic [2:0] MODE_TRANSFER = 3'd4;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_PROC  = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_RIGHTS    = 3'd4;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  process_id;
      logic [31:0] cap_type;
      logic [63:0] resource_key;
      logic [31:0] grant_rights;
      logic [63:0] target_id;
      logic [31:0] required_rights;
   } req_type;

   typedef struct packed {
      logic        success;
      logic [2:0]  status;
      logic [63:0] result_id;
      logic [31:0] found_type;
      logic [63:0] found_resource;
      logic [31:0] found_rights;
   } rsp_type;

   // One stored capability
   typedef struct packed {
      logic [63:0] id;
      logic [31:0] cap_type;
      logic [63:0] resource;
      logic [31:0] rights;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Compare unit verdict
   typedef struct packed {
      logic hit;
      logic rights_ok;
   } match_type;

endpackage

// File: hdl/cte_ram.sv
module cte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: hdl/cte_match.sv
module cte_match (
   input  cte_pkg::entry_type entry,
   input  cte_pkg::req_type   item,
   input  logic [31:0]        port_type,
   input  logic [31:0]        transfer_mask,
   output cte_pkg::match_type verdict
);
   import cte_pkg::*;

   logic [31:0] need;

   // Pick the rights the operation asks for
   assign need = (item.mode == MODE_TRANSFER) ? transfer_mask : item.required_rights;

   // Find-port keys on type and resource, the rest on the id
   always_comb begin
      if (item.mode == MODE_FIND) begin
         verdict.hit = (entry.cap_type == port_type) && (entry.resource == item.resource_key);
      end else begin
         verdict.hit = (entry.id == item.target_id);
      end
      verdict.rights_ok = ((entry.rights & need) == need);
   end

endmodule

// File: hdl/capability_table_engine_core.sv
// Capability table engine: one table of up to ENTRIES capabilities for each of
// PROCESSES processes, all kept in one single-port-write, registered-read RAM,
// with the per-table fill counts in flops. An item is taken when start is high
// and busy is low; its result shows on rsp_item for exactly one cycle with
// rsp_valid high, and must be captured then, since the engine cannot be held
// off. A bad process, a create, a full table, an empty table or an unknown
// mode answer straight from the setup state. Check, find-port and transfer
// lookup walk the table one slot per cycle through a single compare unit and
// answer at the hit or at the last filled slot; revoke walks the same way and
// then passes through the move state to move the last entry into the freed
// slot. A new item may be started in the cycle its result is shown.
module capability_table_engine_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  cte_pkg::req_type                req_item,
   output logic                            rsp_valid,
   output cte_pkg::rsp_type                rsp_item,
   input  logic                            csr_write,
   input  logic [cte_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cte_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cte_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SETUP = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_MOVE  = 2'd3;

   logic [1:0]        state_ff, state_in;
   req_type           req_ff;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [63:0]       id_ff, id_in;
   logic [31:0]       mask_ff, port_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  cnt_ff [PROCESSES];
   logic [CNT_W-1:0]  cnt_in;
   logic              cnt_we;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   entry_type         ram_wdata, ram_rdata;
   match_type         verdict;

   logic              proc_ok;
   logic [PROC_W-1:0] proc_idx;
   logic [CNT_W-1:0]  cur_cnt;
   logic [CNT_W-1:0]  scan_next;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [PROC_W-1:0] p,
                                                   input logic [CNT_W-1:0] s);
      int a;
      a = int'(p) * ENTRIES + int'(s);
      return ADDR_W'(a);
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign proc_ok   = ({1'b0, req_ff.process_id} < 9'(PROCESSES));
   assign proc_idx  = req_ff.process_id[PROC_W-1:0];
   assign cur_cnt   = cnt_ff[proc_idx];
   assign scan_next = scan_ff + 1'b1;

   cte_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   cte_match u_match (
      .entry         (ram_rdata),
      .item          (req_ff),
      .port_type     (port_ff),
      .transfer_mask (mask_ff),
      .verdict       (verdict)
   );

   // Sequence one item: setup, slot walk, optional move
   always_comb begin
      rsp_type res;
      logic    done;
      res          = '0;
      res.status   = ST_NOT_FOUND;
      done         = 1'b0;
      state_in     = state_ff;
      scan_in      = scan_ff;
      pos_in       = pos_ff;
      id_in        = id_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      cnt_we       = 1'b0;
      cnt_in       = cur_cnt;
      ram_we       = 1'b0;
      ram_waddr    = slot_addr(proc_idx, cur_cnt);
      ram_wdata    = ram_rdata;
      ram_raddr    = slot_addr(proc_idx, '0);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (!proc_ok) begin
               res.status = ST_BAD_PROC;
               done       = 1'b1;
            end else begin
               case (req_ff.mode)
                  MODE_CREATE: begin
                     done = 1'b1;
                     if (cur_cnt >= CNT_W'(ENTRIES)) begin
                        res.status = ST_FULL;
                     end else begin
                        ram_we             = 1'b1;
                        ram_wdata.id       = id_ff;
                        ram_wdata.cap_type = req_ff.cap_type;
                        ram_wdata.resource = req_ff.resource_key;
                        ram_wdata.rights   = req_ff.grant_rights;
                        cnt_we             = 1'b1;
                        cnt_in             = cur_cnt + 1'b1;
                        id_in              = id_ff + 64'd1;
                        res.success        = 1'b1;
                        res.status         = ST_OK;
                        res.result_id      = id_ff;
                     end
                  end
                  MODE_CHECK, MODE_REVOKE, MODE_FIND, MODE_TRANSFER: begin
                     if (cur_cnt == '0) begin
                        done = 1'b1;
                     end else begin
                        scan_in  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Prefetch the next slot while the current one is compared
            ram_raddr = slot_addr(proc_idx, scan_next);
            if (verdict.hit) begin
               case (req_ff.mode)
                  MODE_CHECK: begin
                     done = 1'b1;
                     if (verdict.rights_ok) begin
                        res.success = 1'b1;
                        res.status  = ST_OK;
                     end else begin
                        res.status = ST_RIGHTS;
                     end
                  end
                  MODE_REVOKE: begin
                     ram_raddr = slot_addr(proc_idx, cur_cnt - 1'b1);
                     pos_in    = scan_ff;
                     state_in  = S_MOVE;
                  end
                  MODE_FIND: begin
                     done          = 1'b1;
                     res.success   = 1'b1;
                     res.status    = ST_OK;
                     res.result_id = ram_rdata.id;
                  end
                  MODE_TRANSFER: begin
                     done = 1'b1;
                     if (verdict.rights_ok) begin
                        res.success        = 1'b1;
                        res.status         = ST_OK;
                        res.found_type     = ram_rdata.cap_type;
                        res.found_resource = ram_rdata.resource;
                        res.found_rights   = ram_rdata.rights;
                     end else begin
                        res.status = ST_RIGHTS;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end else if (scan_next == cur_cnt) begin
               done = 1'b1;
            end else begin
               scan_in = scan_next;
            end
         end
         S_MOVE: begin
            // Copy the last entry into the revoked slot and shrink the table
            ram_we      = 1'b1;
            ram_waddr   = slot_addr(proc_idx, pos_ff);
            ram_wdata   = ram_rdata;
            cnt_we      = 1'b1;
            cnt_in      = cur_cnt - 1'b1;
            res.success = 1'b1;
            res.status  = ST_OK;
            done        = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (done) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
         state_in     = S_IDLE;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         id_ff        <= 64'd1;
         mask_ff      <= 32'd4;
         port_ff      <= 32'd1;
         for (int p = 0; p < PROCESSES; p++) begin
            cnt_ff[p] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         id_ff        <= id_in;
         if (cnt_we) begin
            cnt_ff[proc_idx] <= cnt_in;
         end
         if (csr_write && csr_index == CSR_TRANSFER_MASK) begin
            mask_ff <= csr_wdata;
         end
         if (csr_write && csr_index == CSR_PORT_TYPE) begin
            port_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_item;
      end
      scan_ff <= scan_in;
      pos_ff  <= pos_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// File: hdl/cte_checker.sv
module cte_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input cte_pkg::rsp_type rsp_item
);
   import cte_pkg::*;

   // An accepted item keeps the engine busy until its result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not make the engine busy");

   // The engine is free again in the cycle its result shows
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   // Leaving busy always delivers a result
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("item finished without a result");

   // Never two results back to back
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // Success and ok status agree
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.success == (rsp_item.status == ST_OK)))
      else $error("success flag disagrees with status");

endmodule

bind capability_table_engine_core cte_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
